// ----- rtl/qct_pkg.sv -----
// ----------------------------------------------------------------------------
// qct_pkg - shared types and constants for the command line tokenizer
// Holds the channel word types, the classified word passed from the front
// to the back, and the byte codes the tokenizer recognises.
// ----------------------------------------------------------------------------
`default_nettype none

package qct_pkg;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // special bytes
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // escape letters and the codes they stand for
    localparam logic [7:0] ESC_A = 8'h61;
    localparam logic [7:0] ESC_B = 8'h62;
    localparam logic [7:0] ESC_F = 8'h66;
    localparam logic [7:0] ESC_N = 8'h6E;
    localparam logic [7:0] ESC_R = 8'h72;
    localparam logic [7:0] ESC_T = 8'h74;
    localparam logic [7:0] ESC_V = 8'h76;
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       token_end;
        logic       done_res;
        logic       error;
    } out_word_t;

    // classified word, front to back
    typedef struct packed {
        logic       is_end;
        logic       is_ws;
        logic       is_sq;
        logic       is_dq;
        logic       is_bsl;
        logic [7:0] ch;
        logic [7:0] esc_ch;
    } cls_word_t;

    // byte that an escaped byte stands for
    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            ESC_A:   r = CODE_BEL;
            ESC_B:   r = CODE_BS;
            ESC_F:   r = CODE_FF;
            ESC_N:   r = CODE_LF;
            ESC_R:   r = CODE_CR;
            ESC_T:   r = CODE_TAB;
            ESC_V:   r = CODE_VT;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/qct_front.sv -----
// ----------------------------------------------------------------------------
// qct_front - input classifier
// Takes input words and tags each byte as whitespace, quote or backslash,
// with its escape mapping worked out, before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qct_front (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  qct_pkg::in_word_t      s_data,
    output logic                   push,
    output qct_pkg::cls_word_t     push_word,
    input  wire logic              queue_full
);
    import qct_pkg::*;

    // accept whenever the queue has room
    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // classify the byte
    always_comb begin
        push_word.is_end = (s_data.kind == KIND_END);
        push_word.is_ws  = ((s_data.ch >= CH_TAB) && (s_data.ch <= CH_CR))
                           || (s_data.ch == CH_SP);
        push_word.is_sq  = (s_data.ch == CH_SQ);
        push_word.is_dq  = (s_data.ch == CH_DQ);
        push_word.is_bsl = (s_data.ch == CH_BSL);
        push_word.ch     = s_data.ch;
        push_word.esc_ch = map_escape(s_data.ch);
    end

endmodule

`default_nettype wire

// ----- rtl/qct_queue.sv -----
// ----------------------------------------------------------------------------
// qct_queue - short queue of classified words
// Decouples the classifier from the token engine so each side can stall
// on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module qct_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  qct_pkg::cls_word_t     push_word,
    output logic                   full,
    input  wire logic              pop,
    output qct_pkg::cls_word_t     pop_word,
    output logic                   empty
);
    import qct_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_word_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_word = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/qct_back.sv -----
// ----------------------------------------------------------------------------
// qct_back - token engine
// Tracks quote, escape and whitespace state, applies each classified byte
// and holds the resulting word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qct_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              queue_empty,
    input  qct_pkg::cls_word_t     pop_word,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qct_pkg::out_word_t     m_data
);
    import qct_pkg::*;

    logic      ws_run_reg,   ws_run_next;
    logic      sq_reg,       sq_next;
    logic      dq_reg,       dq_next;
    logic      prev_bsl_reg, prev_bsl_next;
    logic      esc_reg,      esc_next;
    logic      emit;
    out_word_t res;
    logic      out_valid_reg;
    out_word_t out_reg;

    // take a word when the output register is free or being emptied
    assign pop     = !queue_empty && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // apply one word to the tokenizer state
    always_comb begin
        ws_run_next   = ws_run_reg;
        sq_next       = sq_reg;
        dq_next       = dq_reg;
        prev_bsl_next = prev_bsl_reg;
        esc_next      = esc_reg;
        emit          = 1'b0;
        res           = '0;

        if (pop_word.is_end) begin
            emit         = 1'b1;
            res.done_res = 1'b1;
            if (sq_reg || dq_reg) begin
                res.error = 1'b1;
            end else if (ws_run_reg) begin
                res.token_end = 1'b0;
            end else if (esc_reg) begin
                res.out_char   = CH_BSL;
                res.char_valid = 1'b1;
                res.token_end  = 1'b1;
            end else begin
                res.token_end = 1'b1;
            end
            ws_run_next   = 1'b0;
            sq_next       = 1'b0;
            dq_next       = 1'b0;
            prev_bsl_next = 1'b0;
            esc_next      = 1'b0;
        end else begin
            prev_bsl_next = pop_word.is_bsl;
            if (sq_reg && pop_word.is_sq && !prev_bsl_reg) begin
                // closing single quote, dropped
                sq_next = 1'b0;
            end else if (dq_reg && pop_word.is_dq && !prev_bsl_reg) begin
                // closing double quote, dropped
                dq_next = 1'b0;
            end else if (!sq_reg && !dq_reg && pop_word.is_ws) begin
                // unquoted whitespace ends at most one token per run
                if (!ws_run_reg) begin
                    ws_run_next   = 1'b1;
                    emit          = 1'b1;
                    res.token_end = 1'b1;
                    if (esc_reg) begin
                        res.out_char   = CH_BSL;
                        res.char_valid = 1'b1;
                    end
                    esc_next = 1'b0;
                end
            end else begin
                ws_run_next = 1'b0;
                // quote opens only outside quotes and not after a backslash
                if (!sq_reg && !dq_reg && !prev_bsl_reg) begin
                    if (pop_word.is_sq) begin
                        sq_next = 1'b1;
                    end else if (pop_word.is_dq) begin
                        dq_next = 1'b1;
                    end
                end
                if (esc_reg) begin
                    esc_next       = 1'b0;
                    emit           = 1'b1;
                    res.out_char   = pop_word.esc_ch;
                    res.char_valid = 1'b1;
                end else if (pop_word.is_bsl) begin
                    esc_next = 1'b1;
                end else if (!pop_word.is_sq && !pop_word.is_dq) begin
                    emit           = 1'b1;
                    res.out_char   = pop_word.ch;
                    res.char_valid = 1'b1;
                end
            end
        end
    end

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_run_reg    <= 1'b0;
            sq_reg        <= 1'b0;
            dq_reg        <= 1'b0;
            prev_bsl_reg  <= 1'b0;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                ws_run_reg    <= ws_run_next;
                sq_reg        <= sq_next;
                dq_reg        <= dq_next;
                prev_bsl_reg  <= prev_bsl_next;
                esc_reg       <= esc_next;
                out_valid_reg <= emit;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word, no reset needed
    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/quoted_command_tokenizer.sv -----
// ----------------------------------------------------------------------------
// quoted_command_tokenizer - shell style command line splitter
// Splits a byte stream into tokens at unquoted whitespace, handling quotes
// and backslash escapes; an end word closes the command.
//
//   channel   dir   word            handshake
//   s_        in    in_word_t       s_valid / s_ready
//   m_        out   out_word_t      m_valid / m_ready
//
// One byte per cycle sustained while m_ready stays high; an accepted word is written
// to the queue, then into the token engine's output register, which drives m_.
// Each word gives zero or one result word.
// Synchronous active-low reset clears queue, quote and escape state.
// Input stalls only when the four-entry queue is full; the token engine
// stalls only while its output word is held by m_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_command_tokenizer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  qct_pkg::in_word_t      s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qct_pkg::out_word_t     m_data
);
    import qct_pkg::*;

    logic      push;
    cls_word_t push_word;
    logic      queue_full;
    logic      pop;
    cls_word_t pop_word;
    logic      queue_empty;

    // classifier
    qct_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push       (push),
        .push_word  (push_word),
        .queue_full (queue_full)
    );

    // decoupling queue
    qct_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .full      (queue_full),
        .pop       (pop),
        .pop_word  (pop_word),
        .empty     (queue_empty)
    );

    // token engine
    qct_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .pop_word    (pop_word),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire
